// ----- rtl/rpvg_pkg.sv -----
// Shared types and constants for the regular polygon vertex generator.
// Holds the controller command and status structs, the state enum and the CORDIC table.
// No dependencies.
`default_nettype none
package rpvg_pkg;
   localparam int MAX_SIDES     = 64;
   localparam int MIN_SIDES     = 3;
   localparam int CORDIC_STAGES = 18;
   localparam int SIDES_W       = 7;
   localparam int INDEX_W       = 6;
   localparam int STAGE_W       = 5;
   localparam int DIV_CNT_W     = 6;
   localparam int DIV_LAST      = 32;

   localparam logic signed [31:0] GAIN_Q30     = 32'sd652032874;
   localparam logic        [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic        [31:0] HALF_TURN    = 32'h8000_0000;

   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_ROT_INIT,
      ST_ROT,
      ST_MUL,
      ST_EMIT
   } rpvg_state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic rot_init;
      logic rot_step;
      logic mul;
      logic emit;
   } rpvg_cmd_type;

   typedef struct packed {
      logic div_done;
      logic rot_done;
      logic last;
      logic out_free;
   } rpvg_status_type;
endpackage
`default_nettype wire

// ----- rtl/regular_polygon_vertex_generator_top.sv -----
// Top level of the regular polygon vertex generator.
// Depends on rpvg_pkg, rpvg_ctrl and rpvg_datapath.
//
// Usage:
// The req_ channel carries one circle per transfer: center x, y, z, radius and
// side count. The side count is clamped to 3 through 64. The rsp_ channel returns
// one transfer per polygon vertex, starting at the top of the circle and going
// clockwise, with rsp_last_vertex set on the final vertex.
// After a request is accepted, a bit-serial divider forms the angle step. Each
// vertex then takes an init step, 18 rotation steps in one shared CORDIC stage,
// a multiply step and an output step.
// A new request is accepted only after the last vertex is loaded into the output
// register. A stalled response holds its values; the next vertex is computed
// meanwhile and waits in the datapath until the output register is free.
// Reset is synchronous and active high; it clears the controller and the
// response valid flag.
`default_nettype none
module regular_polygon_vertex_generator_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_center_x,
   input  wire logic signed [31:0] req_center_y,
   input  wire logic signed [31:0] req_center_z,
   input  wire logic        [30:0] req_radius,
   input  wire logic        [6:0]  req_sides,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_vertex_x,
   output logic signed [31:0]      rsp_vertex_y,
   output logic signed [31:0]      rsp_vertex_z,
   output logic        [5:0]       rsp_vertex_index,
   output logic                    rsp_last_vertex
);
   import rpvg_pkg::*;

   rpvg_cmd_type    cmd;
   rpvg_status_type status;

   rpvg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rpvg_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_center_z     (req_center_z),
      .req_radius       (req_radius),
      .req_sides        (req_sides),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_vertex_x     (rsp_vertex_x),
      .rsp_vertex_y     (rsp_vertex_y),
      .rsp_vertex_z     (rsp_vertex_z),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_last_vertex  (rsp_last_vertex)
   );

   a_req_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted but block did not become busy");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_vertex |=> !rsp_valid)
      else $error("response appeared right after the last vertex");

   a_mid_polygon_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_vertex |-> req_stall)
      else $error("block idle while a polygon is still being emitted");
endmodule
`default_nettype wire

// ----- rtl/rpvg_ctrl.sv -----
// Controller state machine of the regular polygon vertex generator.
// Depends on rpvg_pkg for the state enum and the command and status structs.
`default_nettype none
module rpvg_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire rpvg_pkg::rpvg_status_type status,
   output rpvg_pkg::rpvg_cmd_type        cmd
);
   import rpvg_pkg::*;

   rpvg_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = reset || (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_ROT_INIT;
         end
         ST_ROT_INIT: begin
            cmd.rot_init = 1'b1;
            state_in     = ST_ROT;
         end
         ST_ROT: begin
            cmd.rot_step = 1'b1;
            if (status.rot_done) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.last ? ST_IDLE : ST_ROT_INIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

// ----- rtl/rpvg_datapath.sv -----
// Datapath of the regular polygon vertex generator: angle step divider, shared
// CORDIC stage, radius multipliers, rounding, saturation and the output register.
// Depends on rpvg_pkg for constants, the CORDIC table and the command and status structs.
`default_nettype none
module rpvg_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic signed [31:0]       req_center_x,
   input  wire logic signed [31:0]       req_center_y,
   input  wire logic signed [31:0]       req_center_z,
   input  wire logic        [30:0]       req_radius,
   input  wire logic        [6:0]        req_sides,
   input  wire rpvg_pkg::rpvg_cmd_type   cmd,
   output rpvg_pkg::rpvg_status_type     status,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [31:0]            rsp_vertex_x,
   output logic signed [31:0]            rsp_vertex_y,
   output logic signed [31:0]            rsp_vertex_z,
   output logic        [5:0]             rsp_vertex_index,
   output logic                          rsp_last_vertex
);
   import rpvg_pkg::*;

   logic signed [31:0]   cx_ff, cy_ff, cz_ff;
   logic        [30:0]   r_ff;
   logic [SIDES_W-1:0]   n_ff, n_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [SIDES_W-1:0]   rem_ff, rem_shift;
   logic [31:0]          quot_ff, quot_in;
   logic                 qbit;
   logic [31:0]          step_ff, ang_ff;
   logic [INDEX_W-1:0]   k_ff;
   logic signed [31:0]   x_ff, y_ff, z_ff, dx, dy;
   logic [STAGE_W-1:0]   i_ff;
   logic                 flip_ff;
   logic signed [31:0]   cos_v, sin_v, ang_s;
   logic signed [63:0]   px_ff, py_ff;
   logic signed [34:0]   sum_x, sum_y;
   logic                 rsp_valid_ff;
   logic signed [31:0]   vx_ff, vy_ff, vz_ff;
   logic [INDEX_W-1:0]   vi_ff;
   logic                 vl_ff;

   function automatic logic signed [34:0] place(input logic signed [31:0] c,
                                                input logic signed [63:0] p);
      logic signed [63:0] sh;
      sh = (p + 64'sd536870912) >>> 30;
      return {{3{c[31]}}, c} + sh[34:0];
   endfunction

   function automatic logic signed [31:0] sat(input logic signed [34:0] v);
      logic signed [31:0] res;
      if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
         res = v[31:0];
      end else if (v[34]) begin
         res = 32'sh8000_0000;
      end else begin
         res = 32'sh7fff_ffff;
      end
      return res;
   endfunction

   always_comb begin
      n_in = req_sides;
      if (req_sides < SIDES_W'(MIN_SIDES)) n_in = SIDES_W'(MIN_SIDES);
      if (req_sides > SIDES_W'(MAX_SIDES)) n_in = SIDES_W'(MAX_SIDES);
   end

   assign rem_shift = {rem_ff[SIDES_W-2:0], (cnt_ff == '0)};
   assign qbit      = (rem_shift >= n_ff);
   assign quot_in   = {quot_ff[30:0], qbit};
   assign dx        = y_ff >>> i_ff;
   assign dy        = x_ff >>> i_ff;
   assign ang_s     = $signed(ang_ff);
   assign cos_v     = flip_ff ? -x_ff : x_ff;
   assign sin_v     = flip_ff ? -y_ff : y_ff;
   assign sum_x     = place(cx_ff, px_ff);
   assign sum_y     = place(cy_ff, py_ff);

   assign status.div_done = (cnt_ff == DIV_CNT_W'(DIV_LAST));
   assign status.rot_done = (i_ff == STAGE_W'(CORDIC_STAGES - 1));
   assign status.last     = ({1'b0, k_ff} == n_ff - SIDES_W'(1));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff   <= req_center_x;
         cy_ff   <= req_center_y;
         cz_ff   <= req_center_z;
         r_ff    <= req_radius;
         n_ff    <= n_in;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         quot_ff <= '0;
         k_ff    <= '0;
      end
      if (cmd.div_step) begin
         cnt_ff  <= cnt_ff + DIV_CNT_W'(1);
         rem_ff  <= qbit ? rem_shift - n_ff : rem_shift;
         quot_ff <= quot_in;
         if (status.div_done) begin
            step_ff <= quot_in;
            ang_ff  <= QUARTER_TURN;
         end
      end
      if (cmd.rot_init) begin
         x_ff <= GAIN_Q30;
         y_ff <= '0;
         i_ff <= '0;
         if (ang_s > $signed(QUARTER_TURN) || ang_s < -$signed(QUARTER_TURN)) begin
            z_ff    <= $signed(ang_ff ^ HALF_TURN);
            flip_ff <= 1'b1;
         end else begin
            z_ff    <= ang_s;
            flip_ff <= 1'b0;
         end
      end
      if (cmd.rot_step) begin
         i_ff <= i_ff + STAGE_W'(1);
         if (!z_ff[31]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - $signed(ATAN_TABLE[i_ff]);
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + $signed(ATAN_TABLE[i_ff]);
         end
      end
      if (cmd.mul) begin
         px_ff <= $signed({1'b0, r_ff}) * cos_v;
         py_ff <= $signed({1'b0, r_ff}) * sin_v;
      end
      if (cmd.emit) begin
         vx_ff  <= sat(sum_x);
         vy_ff  <= sat(sum_y);
         vz_ff  <= cz_ff;
         vi_ff  <= k_ff;
         vl_ff  <= status.last;
         k_ff   <= k_ff + INDEX_W'(1);
         ang_ff <= ang_ff - step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_x     = vx_ff;
   assign rsp_vertex_y     = vy_ff;
   assign rsp_vertex_z     = vz_ff;
   assign rsp_vertex_index = vi_ff;
   assign rsp_last_vertex  = vl_ff;
endmodule
`default_nettype wire
